FILE: hw/rtl/multi_channel_watchdog_bank_core_assert.svh
// assertion macros shared by the watchdog bank rtl
// no dependencies; included by the files that carry assertions
`ifndef MULTI_CHANNEL_WATCHDOG_BANK_CORE_ASSERT_SVH
`define MULTI_CHANNEL_WATCHDOG_BANK_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MCWDB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MCWDB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mcwdb_pkg.sv
// types, codes and sizes of the multi-channel watchdog bank
// no dependencies; used by the interfaces, controller, datapath and core
package mcwdb_pkg;

  // table size and derived widths
  localparam int CHANNELS    = 16;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int REP_W       = $clog2(MAX_RESULTS + 1);

  // payload field widths
  localparam int FUNC_W    = 3;
  localparam int SLOT_W    = 4;
  localparam int TIMEOUT_W = 16;
  localparam int STATUS_W  = 2;
  localparam int TIME_W    = 32;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY   = 1'd1;
  localparam logic [CFG_DATA_W-1:0] SCAN_INTERVAL_RST = 8'd2;
  localparam logic [CFG_DATA_W-1:0] FIRST_DELAY_RST   = 8'd4;

  // request function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_KICK   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_START  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd5;

  // result codes
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_CHAN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // one request
  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [SLOT_W-1:0]    slot;
    logic [TIMEOUT_W-1:0] timeout;
    logic                 start_now;
  } item_t;

  // one result
  typedef struct packed {
    logic                kind;
    logic [SLOT_W-1:0]   out_slot;
    logic [STATUS_W-1:0] status;
    logic                last;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec_tick;
    logic exec_cmd;
    logic scan_init;
    logic scan_step;
    logic flush;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              scan_due;
    logic              hit;
    logic              pend_valid;
    logic              out_free;
    logic              scan_end;
  } dp_stat_t;

endpackage

FILE: hw/rtl/mcwdb_if.sv
// valid/ready channel interfaces for requests and results
// depends on mcwdb_pkg for field widths
interface mcwdb_req_if;
  logic                               valid;
  logic                               ready;
  logic [mcwdb_pkg::FUNC_W-1:0]       func;
  logic [mcwdb_pkg::SLOT_W-1:0]       slot;
  logic [mcwdb_pkg::TIMEOUT_W-1:0]    timeout;
  logic                               start_now;

  modport source (output valid, func, slot, timeout, start_now, input ready);
  modport sink   (input valid, func, slot, timeout, start_now, output ready);
endinterface

interface mcwdb_res_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [mcwdb_pkg::SLOT_W-1:0]       out_slot;
  logic [mcwdb_pkg::STATUS_W-1:0]     status;
  logic                               last;

  modport source (output valid, kind, out_slot, status, last, input ready);
  modport sink   (input valid, kind, out_slot, status, last, output ready);
endinterface

FILE: hw/rtl/mcwdb_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mcwdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/mcwdb_ctrl.sv
// controller state machine of the watchdog bank
// depends on mcwdb_pkg; drives the datapath through ctl_cmd_t
module mcwdb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  mcwdb_pkg::dp_stat_t stat,
  output mcwdb_pkg::ctl_cmd_t cmd
);
  import mcwdb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_PRIME = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.func)
          FUNC_TICK: begin
            cmd.exec_tick = 1'b1;
            state_next    = stat.scan_due ? S_PRIME : S_IDLE;
          end
          FUNC_CREATE, FUNC_KICK, FUNC_START, FUNC_STOP, FUNC_REMOVE: begin
            // acknowledgement needs room in the result register
            if (stat.out_free) begin
              cmd.exec_cmd = 1'b1;
              state_next   = S_IDLE;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_PRIME: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        // hold the walk while a held report cannot move on
        if (!(stat.hit && stat.pend_valid && !stat.out_free)) begin
          cmd.scan_step = 1'b1;
          if (stat.scan_end) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mcwdb_dp.sv
// datapath of the watchdog bank: channel table, time, scan timer, result register
// depends on mcwdb_pkg, mcwdb_ram and the assertion macro header
`include "multi_channel_watchdog_bank_core_assert.svh"

module mcwdb_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_en,
  input  logic [mcwdb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mcwdb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  mcwdb_pkg::item_t                      in_item,
  input  mcwdb_pkg::ctl_cmd_t                   cmd,
  output mcwdb_pkg::dp_stat_t                   stat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output mcwdb_pkg::res_t                       out_data
);
  import mcwdb_pkg::*;

  // request held for execution
  item_t item;

  // channel flags, time and scan timer
  logic [CHANNELS-1:0]   valid_bits, valid_bits_next;
  logic [CHANNELS-1:0]   run_bits, run_bits_next;
  logic [TIME_W-1:0]     now_seconds;
  logic                  scan_armed, scan_armed_next;
  logic [CFG_DATA_W-1:0] ticks_to_scan, ticks_to_scan_next;
  logic [CFG_DATA_W-1:0] scan_interval;
  logic [CFG_DATA_W-1:0] first_delay;

  // scan walk
  logic [CH_W-1:0]  cmp_idx;
  logic [CH_W-1:0]  rd_addr;
  logic             pend_valid;
  logic [CH_W-1:0]  pend_slot;
  logic [REP_W-1:0] rep_cnt;
  logic             scan_end;
  logic             hit;
  logic [TIME_W-1:0]    elapsed;
  logic [TIMEOUT_W-1:0] tmo_q;
  logic [TIME_W-1:0]    kick_q;

  // command decode
  logic [CH_W-1:0] slot_idx;
  logic            exists;
  logic            free_found;
  logic [CH_W-1:0] free_idx;
  logic            is_create;
  logic            create_ok;
  logic            tmo_we;
  logic            kick_we;
  logic [CH_W-1:0] kick_waddr;

  // result register
  logic out_load;
  res_t out_next;
  logic out_free;
  logic [5:0] cmd_bits;

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
    end
  end

  // addressed channel and lowest free channel
  assign slot_idx = CH_W'(item.slot);
  assign exists   = (int'(item.slot) < CHANNELS) && valid_bits[slot_idx];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!valid_bits[i]) begin
        free_found = 1'b1;
        free_idx   = CH_W'(i);
      end
    end
  end

  assign is_create  = (item.func == FUNC_CREATE);
  assign create_ok  = cmd.exec_cmd && is_create && free_found;
  assign tmo_we     = create_ok;
  assign kick_we    = create_ok || (cmd.exec_cmd && (item.func == FUNC_KICK) && exists);
  assign kick_waddr = is_create ? free_idx : slot_idx;

  // channel flags and scan timer update
  always_comb begin
    logic [CHANNELS-1:0] clr_mask;
    clr_mask           = '0;
    valid_bits_next    = valid_bits;
    run_bits_next      = run_bits;
    scan_armed_next    = scan_armed;
    ticks_to_scan_next = ticks_to_scan;
    if (cmd.exec_tick && scan_armed) begin
      if (ticks_to_scan > CFG_DATA_W'(1)) begin
        ticks_to_scan_next = ticks_to_scan - CFG_DATA_W'(1);
      end else begin
        ticks_to_scan_next = scan_interval;
      end
    end
    if (cmd.exec_cmd) begin
      case (item.func)
        FUNC_CREATE: begin
          if (free_found) begin
            valid_bits_next[free_idx] = 1'b1;
            run_bits_next[free_idx]   = item.start_now;
            if (item.start_now && !scan_armed) begin
              scan_armed_next    = 1'b1;
              ticks_to_scan_next = first_delay;
            end
          end
        end
        FUNC_START: begin
          if (exists) begin
            run_bits_next[slot_idx] = 1'b1;
          end
          if (!scan_armed) begin
            scan_armed_next    = 1'b1;
            ticks_to_scan_next = first_delay;
          end
        end
        FUNC_STOP: begin
          if (exists) begin
            run_bits_next[slot_idx] = 1'b0;
          end
        end
        FUNC_REMOVE: begin
          if (exists) begin
            clr_mask[slot_idx] = 1'b1;
          end
          valid_bits_next = valid_bits & ~clr_mask;
          run_bits_next   = run_bits & ~clr_mask;
          // empty table disarms scanning
          if (valid_bits_next == '0) begin
            scan_armed_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers and configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits    <= '0;
      run_bits      <= '0;
      now_seconds   <= '0;
      scan_armed    <= 1'b0;
      ticks_to_scan <= '0;
      scan_interval <= SCAN_INTERVAL_RST;
      first_delay   <= FIRST_DELAY_RST;
    end else begin
      valid_bits    <= valid_bits_next;
      run_bits      <= run_bits_next;
      scan_armed    <= scan_armed_next;
      ticks_to_scan <= ticks_to_scan_next;
      if (cmd.exec_tick) begin
        now_seconds <= now_seconds + TIME_W'(1);
      end
      if (cfg_en) begin
        case (cfg_index)
          REG_SCAN_INTERVAL: scan_interval <= cfg_data;
          REG_FIRST_DELAY:   first_delay   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // timeout and last kick stores
  mcwdb_ram #(.WIDTH(TIMEOUT_W), .DEPTH(CHANNELS)) u_tmo_ram (
    .clk   (clk),
    .we    (tmo_we),
    .waddr (free_idx),
    .wdata (item.timeout),
    .raddr (rd_addr),
    .rdata (tmo_q)
  );

  mcwdb_ram #(.WIDTH(TIME_W), .DEPTH(CHANNELS)) u_kick_ram (
    .clk   (clk),
    .we    (kick_we),
    .waddr (kick_waddr),
    .wdata (now_seconds),
    .raddr (rd_addr),
    .rdata (kick_q)
  );

  // scan walk: read address runs one entry ahead of the compare
  assign scan_end = (cmp_idx == CH_W'(CHANNELS - 1));

  always_comb begin
    if (cmd.scan_init) begin
      rd_addr = '0;
    end else if (cmd.scan_step && !scan_end) begin
      rd_addr = cmp_idx + CH_W'(1);
    end else begin
      rd_addr = cmp_idx;
    end
  end

  // expiry test on the entry under compare, modular elapsed time
  assign elapsed = now_seconds - kick_q;
  assign hit     = valid_bits[cmp_idx] && run_bits[cmp_idx] &&
                   (elapsed > TIME_W'(tmo_q)) && (rep_cnt < REP_W'(MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      rep_cnt    <= '0;
      cmp_idx    <= '0;
    end else if (cmd.scan_init) begin
      pend_valid <= 1'b0;
      rep_cnt    <= '0;
      cmp_idx    <= '0;
    end else if (cmd.scan_step) begin
      if (hit) begin
        pend_valid <= 1'b1;
        rep_cnt    <= rep_cnt + REP_W'(1);
      end
      if (!scan_end) begin
        cmp_idx <= cmp_idx + CH_W'(1);
      end
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && hit) begin
      pend_slot <= cmp_idx;
    end
  end

  // result register source selection
  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (cmd.exec_cmd) begin
      out_load      = 1'b1;
      out_next.kind = KIND_ACK;
      out_next.last = 1'b1;
      if (is_create) begin
        out_next.out_slot = free_found ? SLOT_W'(free_idx) : '0;
        out_next.status   = free_found ? ST_OK : ST_FULL;
      end else begin
        out_next.out_slot = item.slot;
        out_next.status   = exists ? ST_OK : ST_NO_CHAN;
      end
    end else if ((cmd.scan_step && hit && pend_valid) || cmd.flush) begin
      // held report leaves once the next hit or the end of the walk is known
      out_load          = 1'b1;
      out_next.kind     = KIND_EXPIRED;
      out_next.out_slot = SLOT_W'(pend_slot);
      out_next.status   = ST_OK;
      out_next.last     = cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  assign out_free = !out_valid || out_ready;

  // status to the controller
  assign stat.func       = item.func;
  assign stat.scan_due   = scan_armed && (ticks_to_scan <= CFG_DATA_W'(1));
  assign stat.hit        = hit;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;
  assign stat.scan_end   = scan_end;

  assign cmd_bits = cmd;

  // checks
  `MCWDB_ASSERT_SAME(a_out_no_overwrite, clk, rst, out_load, (!out_valid || out_ready), "result register overwritten while waiting")
  `MCWDB_ASSERT_SAME(a_single_cmd, clk, rst, 1'b1, $onehot0(cmd_bits), "more than one datapath command at once")
  `MCWDB_ASSERT_SAME(a_scan_when_armed, clk, rst, cmd.scan_init, scan_armed, "scan started while disarmed")
  `MCWDB_ASSERT_NEXT(a_flush_empties, clk, rst, cmd.flush, !pend_valid, "held report not cleared by flush")

endmodule

FILE: hw/rtl/multi_channel_watchdog_bank_core.sv
// command or plain tick: captured while idle, then executed; a command waits for room in the result register
// and its acknowledgement is registered there; a plain tick gives no result
// tick that scans: one table entry a cycle through the ram read port, while no report waits on a full result register
// reports wait on a full result register; requests are taken while a result waits
// synchronous reset clears channel flags, time and scan state, registers to 2 and 4;
// timeout and kick stores are not cleared and need no clearing pass
module multi_channel_watchdog_bank_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_en,
  input  logic [mcwdb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mcwdb_pkg::CFG_DATA_W-1:0]      cfg_data,
  mcwdb_req_if.sink                             request,
  mcwdb_res_if.source                           result
);
  import mcwdb_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  item_t    in_item;
  res_t     out_data;
  logic     out_valid;
  logic     req_ready;

  // request payload
  assign in_item.func      = request.func;
  assign in_item.slot      = request.slot;
  assign in_item.timeout   = request.timeout;
  assign in_item.start_now = request.start_now;
  assign request.ready     = req_ready;

  mcwdb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mcwdb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  // result channel
  assign result.valid    = out_valid;
  assign result.kind     = out_data.kind;
  assign result.out_slot = out_data.out_slot;
  assign result.status   = out_data.status;
  assign result.last     = out_data.last;

endmodule

FILE: tb/sv/tb_multi_channel_watchdog_bank_core.sv
`timescale 1ns / 1ps
// self-checking testbench of the multi-channel watchdog bank core
// needs mcwdb_pkg, the request/result interfaces of mcwdb_if and the core itself
module tb_multi_channel_watchdog_bank_core;
  import mcwdb_pkg::*;

  // unused function codes, ignored by the core
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  localparam int SETTLE_CYCLES = 4 + CHANNELS + 12;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASE_ITEMS   = 27;
  localparam int PHASES        = 6;

  // how a row of the directed plan is checked
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_ACK} chk_e;

  typedef struct {
    item_t               it;
    int                  reps;
    chk_e                chk;
    logic [SLOT_W-1:0]   want_slot;
    logic [STATUS_W-1:0] want_status;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mcwdb_req_if req_ch ();
  mcwdb_res_if res_ch ();

  multi_channel_watchdog_bank_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (req_ch),
    .result    (res_ch)
  );

  always #5 clk = ~clk;

  // predicted channel table, clock and scan state
  logic [CHANNELS-1:0]  chan_valid = '0;
  logic [CHANNELS-1:0]  chan_run   = '0;
  logic [TIMEOUT_W-1:0] chan_limit  [CHANNELS];
  logic [TIME_W-1:0]    chan_kicked [CHANNELS];
  logic [TIME_W-1:0]    seconds        = '0;
  logic                 scan_on        = 1'b0;
  logic [7:0]           scan_countdown = '0;
  logic [7:0]           interval_reg   = SCAN_INTERVAL_RST;
  logic [7:0]           delay_reg      = FIRST_DELAY_RST;

  res_t step_out[$];
  res_t ack_report_q[$];
  row_t plan[$];

  logic calm = 1'b0;
  int   mismatches = 0;
  int   stalled = 0;

  function automatic res_t ack_of(input logic [SLOT_W-1:0] slot,
                                  input logic [STATUS_W-1:0] status);
    res_t r;
    r = '{kind: KIND_ACK, out_slot: slot, status: status, last: 1'b1};
    return r;
  endfunction

  function automatic void arm_scan();
    if (!scan_on) begin
      scan_on = 1'b1;
      scan_countdown = delay_reg;
    end
  endfunction

  // results that one request causes, table and clock updated alongside
  function automatic void watchdog_step(input item_t it);
    logic [CHANNELS-1:0] expired;
    logic [TIME_W-1:0]   elapsed;
    int                  top;
    int                  free_slot;
    logic                known;
    step_out.delete();
    known = chan_valid[it.slot];
    case (it.func)
      FUNC_TICK: begin
        seconds = seconds + 1;
        if (scan_on) begin
          if (scan_countdown > 8'd1) begin
            scan_countdown = scan_countdown - 8'd1;
          end else begin
            scan_countdown = interval_reg;
            expired = '0;
            top = -1;
            for (int i = 0; i < CHANNELS; i++) begin
              elapsed = seconds - chan_kicked[i];
              if (chan_valid[i] && chan_run[i] && elapsed > {16'd0, chan_limit[i]}) begin
                expired[i] = 1'b1;
                top = i;
              end
            end
            for (int i = 0; i < CHANNELS; i++) begin
              if (expired[i])
                step_out.push_back('{kind: KIND_EXPIRED, out_slot: SLOT_W'(i),
                                     status: ST_OK, last: (i == top)});
            end
          end
        end
      end
      FUNC_CREATE: begin
        free_slot = -1;
        for (int i = 0; i < CHANNELS; i++)
          if (!chan_valid[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          step_out.push_back(ack_of('0, ST_FULL));
        end else begin
          chan_valid[free_slot]  = 1'b1;
          chan_run[free_slot]    = 1'b0;
          chan_limit[free_slot]  = it.timeout;
          chan_kicked[free_slot] = seconds;
          if (it.start_now) begin
            chan_run[free_slot] = 1'b1;
            arm_scan();
          end
          step_out.push_back(ack_of(SLOT_W'(free_slot), ST_OK));
        end
      end
      FUNC_KICK: begin
        if (known) chan_kicked[it.slot] = seconds;
        step_out.push_back(ack_of(it.slot, known ? ST_OK : ST_NO_CHAN));
      end
      FUNC_START: begin
        // start arms even for a channel that does not exist
        if (known) chan_run[it.slot] = 1'b1;
        arm_scan();
        step_out.push_back(ack_of(it.slot, known ? ST_OK : ST_NO_CHAN));
      end
      FUNC_STOP: begin
        if (known) chan_run[it.slot] = 1'b0;
        step_out.push_back(ack_of(it.slot, known ? ST_OK : ST_NO_CHAN));
      end
      FUNC_REMOVE: begin
        if (known) begin
          chan_valid[it.slot] = 1'b0;
          chan_run[it.slot]   = 1'b0;
        end
        // an empty table disarms, whether or not the slot existed
        if (chan_valid == '0) scan_on = 1'b0;
        step_out.push_back(ack_of(it.slot, known ? ST_OK : ST_NO_CHAN));
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(input logic [FUNC_W-1:0] func, input int slot,
                                  input int tmo, input int start_now, input int reps,
                                  input chk_e chk, input int want_slot,
                                  input logic [STATUS_W-1:0] want_status);
    row_t r;
    r.it          = '{func: func, slot: SLOT_W'(slot), timeout: TIMEOUT_W'(tmo),
                      start_now: start_now[0]};
    r.reps        = reps;
    r.chk         = chk;
    r.want_slot   = SLOT_W'(want_slot);
    r.want_status = want_status;
    plan.push_back(r);
  endfunction

  // slot pick lands on a live channel most of the time
  function automatic logic [SLOT_W-1:0] pick_slot();
    int live[$];
    for (int i = 0; i < CHANNELS; i++)
      if (chan_valid[i]) live.push_back(i);
    if (live.size() > 0 && $urandom_range(99) < 80)
      return SLOT_W'(live[$urandom_range(live.size() - 1)]);
    return SLOT_W'($urandom_range(15));
  endfunction

  // one request: random gap, then hold until taken
  task automatic send_request(input item_t it, input chk_e chk, input res_t want);
    while (!calm && $urandom_range(99) < 17) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= it.func;
    req_ch.slot      <= it.slot;
    req_ch.timeout   <= it.timeout;
    req_ch.start_now <= it.start_now;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    watchdog_step(it);
    case (chk)
      CHK_PRED: foreach (step_out[j]) ack_report_q.push_back(step_out[j]);
      CHK_ACK:  ack_report_q.push_back(want);
      default:  ;
    endcase
    @(negedge clk);
  endtask

  // sender holds off until every result is in and the core has settled
  task automatic wait_quiet();
    req_ch.valid <= 1'b0;
    while (ack_report_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_timing(input logic [7:0] interval, input logic [7:0] delay);
    cfg_en    <= 1'b1;
    cfg_index <= REG_SCAN_INTERVAL;
    cfg_data  <= interval;
    @(negedge clk);
    cfg_index <= REG_FIRST_DELAY;
    cfg_data  <= delay;
    @(negedge clk);
    cfg_en <= 1'b0;
    interval_reg = interval;
    delay_reg    = delay;
  endtask

  task automatic flag_mismatch(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch, %s: expected kind %0d slot %0d status %0d last %0d, got kind %0d slot %0d status %0d last %0d",
               what, want.kind, want.out_slot, want.status, want.last,
               got.kind, got.out_slot, got.status, got.last);
  endtask

  // result side stalls at random unless in a calm stretch
  always @(negedge clk) begin
    res_ch.ready <= calm || ($urandom_range(99) >= 17);
  end

  // compare each result with the oldest outstanding one
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{kind: res_ch.kind, out_slot: res_ch.out_slot, status: res_ch.status,
              last: res_ch.last};
      if (ack_report_q.size() == 0) begin
        flag_mismatch("nothing outstanding", '0, got);
      end else begin
        want = ack_report_q.pop_front();
        if (got.kind !== want.kind || got.out_slot !== want.out_slot ||
            got.status !== want.status || got.last !== want.last)
          flag_mismatch("wrong field", want, got);
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst) begin
      stalled <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stalled <= 0;
    end else begin
      stalled <= stalled + 1;
      if (stalled >= IDLE_LIMIT) begin
        $display("tb_multi_channel_watchdog_bank_core failed");
        $finish;
      end
    end
  end

  initial begin
    item_t it;
    int    sent;
    int    pick;
    rst              = 1'b1;
    cfg_en           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    req_ch.valid     = 1'b0;
    req_ch.func      = '0;
    req_ch.slot      = '0;
    req_ch.timeout   = '0;
    req_ch.start_now = 1'b0;
    res_ch.ready     = 1'b0;

    // directed plan: bad slots on an empty table, first scan, arming and
    // disarming by absent channels, ignored codes, a full table, sixteen reports
    add_row(FUNC_KICK,     15, 16'hffff, 1, 1,  CHK_ACK,  15, ST_NO_CHAN);
    add_row(FUNC_REMOVE,   3,  0,        0, 1,  CHK_ACK,  3,  ST_NO_CHAN);
    add_row(FUNC_TICK,     0,  0,        0, 1,  CHK_NONE, 0,  ST_OK);
    add_row(FUNC_CREATE,   7,  0,        0, 1,  CHK_ACK,  0,  ST_OK);
    add_row(FUNC_CREATE,   0,  16'hffff, 1, 1,  CHK_ACK,  1,  ST_OK);
    add_row(FUNC_START,    0,  0,        0, 1,  CHK_ACK,  0,  ST_OK);
    add_row(FUNC_TICK,     0,  0,        0, 4,  CHK_PRED, 0,  ST_OK);
    add_row(FUNC_KICK,     1,  0,        0, 1,  CHK_ACK,  1,  ST_OK);
    add_row(FUNC_STOP,     0,  0,        0, 1,  CHK_ACK,  0,  ST_OK);
    add_row(FUNC_START,    9,  0,        0, 1,  CHK_ACK,  9,  ST_NO_CHAN);
    add_row(FUNC_TICK,     0,  0,        0, 1,  CHK_PRED, 0,  ST_OK);
    add_row(FUNC_SPARE_LO, 5,  16'h00ff, 1, 1,  CHK_NONE, 0,  ST_OK);
    add_row(FUNC_SPARE_HI, 10, 16'hff00, 0, 1,  CHK_NONE, 0,  ST_OK);
    add_row(FUNC_REMOVE,   0,  0,        0, 1,  CHK_ACK,  0,  ST_OK);
    add_row(FUNC_REMOVE,   1,  0,        0, 1,  CHK_ACK,  1,  ST_OK);
    add_row(FUNC_START,    12, 0,        0, 1,  CHK_ACK,  12, ST_NO_CHAN);
    add_row(FUNC_TICK,     0,  0,        0, 1,  CHK_NONE, 0,  ST_OK);
    add_row(FUNC_REMOVE,   12, 0,        0, 1,  CHK_ACK,  12, ST_NO_CHAN);
    add_row(FUNC_CREATE,   0,  1,        1, 16, CHK_PRED, 0,  ST_OK);
    add_row(FUNC_CREATE,   0,  2,        0, 1,  CHK_ACK,  0,  ST_FULL);
    add_row(FUNC_TICK,     0,  0,        0, 4,  CHK_PRED, 0,  ST_OK);

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k])
      repeat (plan[k].reps)
        send_request(plan[k].it, plan[k].chk,
                     ack_of(plan[k].want_slot, plan[k].want_status));

    // random phases, each under its own scan timing
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_quiet();
      case (phase)
        0:       set_timing(8'd1, 8'd1);
        1:       set_timing(8'd0, 8'd0);
        2:       set_timing(8'd255, 8'd1);
        3:       set_timing(8'd1, 8'd255);
        default: set_timing(8'($urandom_range(1, 9)), 8'($urandom_range(1, 9)));
      endcase
      calm = (phase == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        it.slot      = SLOT_W'($urandom_range(15));
        it.timeout   = ($urandom_range(99) < 70) ? TIMEOUT_W'($urandom_range(12))
                                                 : TIMEOUT_W'($urandom_range(65535));
        it.start_now = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 3)       it.func = $urandom_range(1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
        else if (pick < 40) it.func = FUNC_TICK;
        else if (pick < 55) it.func = FUNC_CREATE;
        else if (pick < 68) it.func = FUNC_KICK;
        else if (pick < 78) it.func = FUNC_START;
        else if (pick < 86) it.func = FUNC_STOP;
        else                it.func = FUNC_REMOVE;
        if (it.func >= FUNC_KICK && it.func <= FUNC_REMOVE) it.slot = pick_slot();
        send_request(it, CHK_PRED, '0);
        if (it.func != FUNC_SPARE_LO && it.func != FUNC_SPARE_HI) sent++;
      end
      calm = 1'b0;
    end

    wait_quiet();
    if (mismatches == 0)
      $display("tb_multi_channel_watchdog_bank_core passed");
    else
      $display("tb_multi_channel_watchdog_bank_core failed");
    $finish;
  end

endmodule
